// ----- rtl/tct_pkg.sv -----
// Shared types, constants and codes of the TCP connection tracker.
package tct_pkg;

    localparam int CONN_ENTRIES = 16;
    localparam int IDX_W        = $clog2(CONN_ENTRIES);
    localparam int CNT_W        = $clog2(CONN_ENTRIES + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int REMOVED_W = 5;
    localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

    // Result status codes.
    localparam logic [2:0] STS_UPDATED  = 3'd0;
    localparam logic [2:0] STS_INSERTED = 3'd1;
    localparam logic [2:0] STS_NOT_SYN  = 3'd2;
    localparam logic [2:0] STS_ACK_BAD  = 3'd3;
    localparam logic [2:0] STS_SYN_DROP = 3'd4;
    localparam logic [2:0] STS_FULL     = 3'd5;
    localparam logic [2:0] STS_TICK     = 3'd6;

    // Connection flag bits.
    localparam int FL_SYN_INT = 0;
    localparam int FL_SYN_EXT = 1;
    localparam int FL_SA_INT  = 2;
    localparam int FL_SA_EXT  = 3;
    localparam int FL_EST     = 4;
    localparam int FL_SIM     = 5;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_EST_TO = 2'd0;
    localparam logic [1:0] REG_TRN_TO = 2'd1;
    localparam logic [1:0] REG_UNS_TO = 2'd2;

    typedef struct packed {
        logic        kind;
        logic        direction;
        logic [31:0] int_ip;
        logic [15:0] int_port;
        logic [31:0] ext_ip;
        logic [15:0] ext_port;
        logic        syn_flag;
        logic        ack_flag;
        logic [31:0] seq_no;
        logic [31:0] ack_no;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic                 conn_established;
        logic                 simultaneous;
        logic [REMOVED_W-1:0] removed_count;
    } out_item_t;

    typedef enum logic {
        OP_PACKET,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t      op;
        in_item_t item;
    } cmd_t;

    typedef struct packed {
        logic [15:0] est_to;
        logic [15:0] trn_to;
        logic [15:0] uns_to;
    } cfg_t;

    typedef struct packed {
        logic [31:0] int_ip;
        logic [15:0] int_port;
        logic [31:0] ext_ip;
        logic [15:0] ext_port;
        logic [5:0]  flags;
        logic [31:0] int_seq;
        logic [31:0] ext_seq;
        logic [31:0] trn_time;
        logic [31:0] est_time;
    } entry_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_EXEC
    } eng_state_t;

endpackage

// ----- rtl/tcp_connection_tracker.sv -----
// Top level of the NAT TCP connection tracker: configuration registers, front end and engine.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  request  | req_valid, req_stall | req: packet event or one-second tick
//  response | rsp_valid, rsp_stall | rsp: status, state flags, removed entry count
//  config   | APB write and read   | three 16-bit timeouts at byte addresses 0, 4, 8
//
// Each item is taken from the queue, then every table entry is read in turn through the
// single read port of the table memory; the scan then hands over to the result step,
// which applies the result and loads the response register. The engine takes the next
// item from the queue only once it is back in its idle state.
// Reset clears the table valid bits, the seconds counter and all handshake state; the
// timeouts return to 7440, 240 and 6 seconds. A two-item queue keeps accepting requests
// until full while the engine works or a finished response is held against rsp_stall.
module tcp_connection_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tct_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tct_pkg::out_item_t rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tct_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_we;
    logic [1:0] reg_idx;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;

    // The register index is the word address; low address bits are ignored.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_EST_TO: prdata = {16'd0, cfg_reg.est_to};
            REG_TRN_TO: prdata = {16'd0, cfg_reg.trn_to};
            REG_UNS_TO: prdata = {16'd0, cfg_reg.uns_to};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.est_to <= 16'd7440;
            cfg_reg.trn_to <= 16'd240;
            cfg_reg.uns_to <= 16'd6;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_EST_TO: cfg_reg.est_to <= pwdata[15:0];
                REG_TRN_TO: cfg_reg.trn_to <= pwdata[15:0];
                REG_UNS_TO: cfg_reg.uns_to <= pwdata[15:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front end classifies each item and buffers it for the engine.
    tct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // The engine scans the table once per item and owns the response register.
    tct_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg_reg),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Only ticks report removed entries.
    a_removed_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STS_TICK |-> rsp.removed_count == '0)
        else $error("removed count reported for a packet");

    // Packets rejected as not SYN or for a full table, and ticks, carry no connection state.
    a_reject_no_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STS_NOT_SYN || rsp.status == STS_FULL ||
                      rsp.status == STS_TICK)
        |-> !rsp.conn_established && !rsp.simultaneous)
        else $error("state flags set on a rejected packet or tick");

    // A simultaneous open always ends established.
    a_sim_implies_est: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.simultaneous |-> rsp.conn_established)
        else $error("simultaneous open without established state");

endmodule

// ----- rtl/tct_front.sv -----
// Front end: accepts items, classifies them and queues them for the engine.
module tct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tct_pkg::in_item_t req,
    output logic              cmd_valid,
    output tct_pkg::cmd_t     cmd,
    input  logic              cmd_pop
);
    import tct_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    cmd_t              cls;

    assign req_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cls.item = req;
        cls.op   = req.kind ? OP_TICK : OP_PACKET;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/tct_engine.sv -----
// Back end: connection table, lookup and expiry scans, handshake rules and result register.
module tct_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  tct_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  tct_pkg::cfg_t      cfg,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tct_pkg::out_item_t rsp
);
    import tct_pkg::*;

    eng_state_t state_reg, state_next;

    entry_t mem [CONN_ENTRIES];

    cmd_t                    cmd_reg;
    logic [31:0]             sec_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    entry_t                  rd_data_reg;
    logic [CONN_ENTRIES-1:0] valid_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    entry_t                  hit_entry_reg;
    logic                    free_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [REMOVED_W-1:0]    removed_reg;
    logic                    rsp_valid_reg;
    out_item_t               rsp_reg;

    logic issue;
    logic out_free;
    logic exec_fire;

    logic        ent_valid;
    logic        key_match;
    logic        kill;
    logic [31:0] rd_trn_el;
    logic [31:0] rd_est_el;

    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             ins;
    out_item_t        res;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: if (cmd_valid) state_next = ENG_SCAN;
            ENG_SCAN: if (cnt_reg == CNT_W'(CONN_ENTRIES) && !rd_vld_reg) state_next = ENG_EXEC;
            ENG_EXEC: if (out_free) state_next = ENG_IDLE;
            default:  state_next = ENG_IDLE;
        endcase
    end

    always_comb
    begin
        out_free  = !rsp_valid_reg || !rsp_stall;
        cmd_pop   = 1'b0;
        issue     = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            ENG_IDLE: cmd_pop   = cmd_valid;
            ENG_SCAN: issue     = (cnt_reg != CNT_W'(CONN_ENTRIES));
            ENG_EXEC: exec_fire = out_free;
            default:  cmd_pop   = 1'b0;
        endcase
    end

    // Scan evaluation of the entry read in the previous cycle.
    always_comb
    begin
        ent_valid = valid_reg[rd_idx_reg];
        key_match = (rd_data_reg.int_ip == cmd_reg.item.int_ip)
                 && (rd_data_reg.int_port == cmd_reg.item.int_port)
                 && (rd_data_reg.ext_ip == cmd_reg.item.ext_ip)
                 && (rd_data_reg.ext_port == cmd_reg.item.ext_port);
        rd_trn_el = sec_reg - rd_data_reg.trn_time;
        rd_est_el = sec_reg - rd_data_reg.est_time;
        if (rd_data_reg.flags[FL_EST])
        begin
            kill = (rd_est_el >= {16'd0, cfg.est_to});
        end
        else
        begin
            kill = (rd_trn_el >= {16'd0, cfg.trn_to})
                || (rd_data_reg.flags[FL_SYN_EXT] && (rd_trn_el >= {16'd0, cfg.uns_to}));
        end
    end

    // Handshake rules applied to the hit entry, or insertion on a miss.
    always_comb
    begin
        logic [5:0]  f;
        logic [2:0]  st;
        logic [1:0]  need;
        logic [31:0] trn_el;
        f      = hit_entry_reg.flags;
        st     = STS_UPDATED;
        need   = 2'b00;
        trn_el = sec_reg - hit_entry_reg.trn_time;
        wdata  = hit_entry_reg;
        we     = 1'b0;
        ins    = 1'b0;
        waddr  = hit_idx_reg;
        res    = '0;

        if (cmd_reg.op == OP_TICK)
        begin
            res.status        = STS_TICK;
            res.removed_count = removed_reg;
        end
        else if (!hit_reg)
        begin
            if (!cmd_reg.item.syn_flag)
            begin
                res.status = STS_NOT_SYN;
            end
            else if (!free_reg)
            begin
                res.status = STS_FULL;
            end
            else
            begin
                res.status     = STS_INSERTED;
                we             = 1'b1;
                ins            = 1'b1;
                waddr          = free_idx_reg;
                wdata.int_ip   = cmd_reg.item.int_ip;
                wdata.int_port = cmd_reg.item.int_port;
                wdata.ext_ip   = cmd_reg.item.ext_ip;
                wdata.ext_port = cmd_reg.item.ext_port;
                wdata.flags    = '0;
                wdata.flags[FL_SYN_INT] = cmd_reg.item.direction;
                wdata.flags[FL_SYN_EXT] = !cmd_reg.item.direction;
                wdata.int_seq  = cmd_reg.item.direction ? cmd_reg.item.seq_no : 32'd0;
                wdata.ext_seq  = cmd_reg.item.direction ? 32'd0 : cmd_reg.item.seq_no;
                wdata.trn_time = sec_reg;
                wdata.est_time = sec_reg;
            end
        end
        else
        begin
            if (cmd_reg.item.syn_flag)
            begin
                if (!cmd_reg.item.direction)
                begin
                    if (cmd_reg.item.ack_flag)
                    begin
                        if (cmd_reg.item.ack_no != hit_entry_reg.int_seq + 32'd1)
                        begin
                            st = STS_ACK_BAD;
                        end
                        else
                        begin
                            f[FL_SA_EXT]  = 1'b1;
                            wdata.ext_seq = cmd_reg.item.seq_no;
                        end
                    end
                    else
                    begin
                        f[FL_SYN_EXT] = 1'b1;
                        wdata.ext_seq = cmd_reg.item.seq_no;
                    end
                end
                else
                begin
                    if (cmd_reg.item.ack_flag)
                    begin
                        if (cmd_reg.item.ack_no != hit_entry_reg.ext_seq + 32'd1)
                        begin
                            st = STS_ACK_BAD;
                        end
                        else
                        begin
                            f[FL_SA_INT]  = 1'b1;
                            wdata.int_seq = cmd_reg.item.seq_no;
                        end
                    end
                    else
                    begin
                        f[FL_SYN_INT] = 1'b1;
                        if (trn_el < {16'd0, cfg.uns_to} && f[FL_SYN_EXT] && !f[FL_EST])
                        begin
                            f[FL_SYN_EXT] = 1'b0;
                            st = STS_SYN_DROP;
                        end
                    end
                end
                if (st == STS_UPDATED)
                begin
                    if (f[FL_EST])
                    begin
                        wdata.est_time = sec_reg;
                    end
                    else if (f[FL_SA_EXT:FL_SYN_INT] == 4'b1111)
                    begin
                        f[FL_EST]      = 1'b1;
                        f[FL_SIM]      = 1'b1;
                        wdata.est_time = sec_reg;
                    end
                end
            end
            if (cmd_reg.item.ack_flag && st == STS_UPDATED)
            begin
                need = cmd_reg.item.direction ? {f[FL_SA_EXT], f[FL_SYN_INT]}
                                              : {f[FL_SA_INT], f[FL_SYN_EXT]};
                if (f[FL_EST])
                begin
                    wdata.est_time = sec_reg;
                end
                else if (need == 2'b11)
                begin
                    f[FL_EST]      = 1'b1;
                    wdata.est_time = sec_reg;
                end
            end
            wdata.flags          = f;
            we                   = (st != STS_ACK_BAD);
            res.status           = st;
            res.conn_established = f[FL_EST];
            res.simultaneous     = f[FL_SIM];
        end
    end

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (exec_fire && we)
        begin
            mem[waddr] <= wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (issue)
        begin
            rd_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (rd_vld_reg && ent_valid && key_match && !hit_reg)
        begin
            hit_idx_reg   <= rd_idx_reg;
            hit_entry_reg <= rd_data_reg;
        end
        if (rd_vld_reg && !ent_valid && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (exec_fire)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            sec_reg       <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (cmd_pop)
            begin
                cnt_reg     <= '0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
                removed_reg <= '0;
                if (cmd.op == OP_TICK)
                begin
                    sec_reg <= sec_reg + 32'd1;
                end
            end
            if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (rd_vld_reg && cmd_reg.op == OP_PACKET)
            begin
                if (ent_valid && key_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (!ent_valid)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (rd_vld_reg && cmd_reg.op == OP_TICK && ent_valid && kill)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
                if (removed_reg != REMOVED_MAX)
                begin
                    removed_reg <= removed_reg + 1'b1;
                end
            end
            if (exec_fire && ins)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (exec_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/tcp_connection_tracker_tb.sv -----
// Testbench for the TCP connection tracker: directed table, random traffic and a reference predictor.
module tcp_connection_tracker_tb;
    import tct_pkg::*;

    // Flag bit masks of one connection entry, in the order of the package flag indexes.
    localparam logic [5:0] M_SYN_INT = 6'h01;
    localparam logic [5:0] M_SYN_EXT = 6'h02;
    localparam logic [5:0] M_SA_INT  = 6'h04;
    localparam logic [5:0] M_SA_EXT  = 6'h08;
    localparam logic [5:0] M_EST     = 6'h10;
    localparam logic [5:0] M_SIM     = 6'h20;
    localparam logic M_IN  = 1'b0;
    localparam logic M_OUT = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1150;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    in_item_t req;
    logic rsp_valid;
    logic rsp_stall;
    out_item_t rsp;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    tcp_connection_tracker i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow copy of the tracker: timeouts, connection table and the seconds clock.
    logic [15:0] est_to, trn_to, uns_to;
    logic        tbl_valid [CONN_ENTRIES];
    entry_t      tbl [CONN_ENTRIES];
    logic [31:0] seconds;

    out_item_t expected_rsp[$];
    int errors = 0;
    int idle_cycles = 0;
    bit long_hold = 0;

    function automatic out_item_t mk_rsp(logic [2:0] st, logic e, logic s, logic [4:0] r);
        out_item_t o;
        o.status = st;
        o.conn_established = e;
        o.simultaneous = s;
        o.removed_count = r;
        return o;
    endfunction

    function automatic void tracker_reset();
        est_to = 16'd7440;
        trn_to = 16'd240;
        uns_to = 16'd6;
        seconds = '0;
        for (int i = 0; i < CONN_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl[i] = '0;
        end
    endfunction

    // Advances the clock by one second and ages out expired connections.
    function automatic out_item_t age_table();
        logic [4:0] gone;
        logic [31:0] el;
        logic kill;
        gone = '0;
        seconds = seconds + 32'd1;
        for (int i = 0; i < CONN_ENTRIES; i++)
        begin
            if (tbl_valid[i])
            begin
                kill = 1'b0;
                if (tbl[i].flags & M_EST)
                    kill = (seconds - tbl[i].est_time) >= {16'd0, est_to};
                else
                begin
                    el = seconds - tbl[i].trn_time;
                    if (el >= {16'd0, trn_to})
                        kill = 1'b1;
                    else if ((tbl[i].flags & M_SYN_EXT) && el >= {16'd0, uns_to})
                        kill = 1'b1;
                end
                if (kill)
                begin
                    tbl_valid[i] = 1'b0;
                    if (gone != 5'd31)
                        gone = gone + 5'd1;
                end
            end
        end
        return mk_rsp(STS_TICK, 1'b0, 1'b0, gone);
    endfunction

    // Applies the handshake rules to a connection that was found in the table.
    function automatic logic [2:0] apply_handshake(int i, in_item_t p);
        logic [5:0] f;
        logic [5:0] need;
        logic [5:0] all4;
        f = tbl[i].flags;
        all4 = M_SYN_INT | M_SYN_EXT | M_SA_INT | M_SA_EXT;
        if (p.syn_flag)
        begin
            if (p.direction == M_IN)
            begin
                if (p.ack_flag)
                begin
                    if (p.ack_no != tbl[i].int_seq + 32'd1)
                        return STS_ACK_BAD;
                    f |= M_SA_EXT;
                end
                else
                    f |= M_SYN_EXT;
                tbl[i].ext_seq = p.seq_no;
            end
            else if (p.ack_flag)
            begin
                if (p.ack_no != tbl[i].ext_seq + 32'd1)
                    return STS_ACK_BAD;
                f |= M_SA_INT;
                tbl[i].int_seq = p.seq_no;
            end
            else
            begin
                f |= M_SYN_INT;
                // An outbound SYN answering a recent unsolicited inbound SYN is dropped.
                if ((seconds - tbl[i].trn_time) < {16'd0, uns_to} && (f & M_SYN_EXT)
                    && !(f & M_EST))
                begin
                    tbl[i].flags = f & ~M_SYN_EXT;
                    return STS_SYN_DROP;
                end
            end
            if (f & M_EST)
                tbl[i].est_time = seconds;
            else if ((f & all4) == all4)
            begin
                f |= M_EST | M_SIM;
                tbl[i].est_time = seconds;
            end
        end
        if (p.ack_flag)
        begin
            need = (p.direction == M_OUT) ? (M_SYN_INT | M_SA_EXT) : (M_SYN_EXT | M_SA_INT);
            if (f & M_EST)
                tbl[i].est_time = seconds;
            else if ((f & need) == need)
            begin
                f |= M_EST;
                tbl[i].est_time = seconds;
            end
        end
        tbl[i].flags = f;
        return STS_UPDATED;
    endfunction

    // Works out the response to one item and updates the shadow table.
    function automatic out_item_t track_item(in_item_t p);
        int hit;
        int free_idx;
        logic [2:0] st;
        hit = -1;
        free_idx = -1;
        if (p.kind)
            return age_table();
        for (int i = 0; i < CONN_ENTRIES; i++)
        begin
            if (tbl_valid[i])
            begin
                if (hit < 0 && tbl[i].int_ip == p.int_ip && tbl[i].int_port == p.int_port
                    && tbl[i].ext_ip == p.ext_ip && tbl[i].ext_port == p.ext_port)
                    hit = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (hit < 0)
        begin
            if (!p.syn_flag)
                return mk_rsp(STS_NOT_SYN, 1'b0, 1'b0, 5'd0);
            if (free_idx < 0)
                return mk_rsp(STS_FULL, 1'b0, 1'b0, 5'd0);
            tbl_valid[free_idx] = 1'b1;
            tbl[free_idx].int_ip = p.int_ip;
            tbl[free_idx].int_port = p.int_port;
            tbl[free_idx].ext_ip = p.ext_ip;
            tbl[free_idx].ext_port = p.ext_port;
            tbl[free_idx].flags = p.direction ? M_SYN_INT : M_SYN_EXT;
            tbl[free_idx].int_seq = p.direction ? p.seq_no : 32'd0;
            tbl[free_idx].ext_seq = p.direction ? 32'd0 : p.seq_no;
            tbl[free_idx].trn_time = seconds;
            tbl[free_idx].est_time = seconds;
            return mk_rsp(STS_INSERTED, 1'b0, 1'b0, 5'd0);
        end
        st = apply_handshake(hit, p);
        return mk_rsp(st, (tbl[hit].flags & M_EST) != 0, (tbl[hit].flags & M_SIM) != 0, 5'd0);
    endfunction

    // Response checker: every accepted response is matched against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response with nothing expected: %p", rsp);
                errors++;
            end
            else
            begin
                exp_r = expected_rsp.pop_front();
                if (rsp.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, rsp.status);
                    errors++;
                end
                if (rsp.conn_established !== exp_r.conn_established)
                begin
                    $error("conn_established: expected %0d, got %0d",
                           exp_r.conn_established, rsp.conn_established);
                    errors++;
                end
                if (rsp.simultaneous !== exp_r.simultaneous)
                begin
                    $error("simultaneous: expected %0d, got %0d",
                           exp_r.simultaneous, rsp.simultaneous);
                    errors++;
                end
                if (rsp.removed_count !== exp_r.removed_count)
                begin
                    $error("removed_count: expected %0d, got %0d",
                           exp_r.removed_count, rsp.removed_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stall pattern: runs of ready and stalled cycles, plus one long hold-off
    // on request so that the internal queue fills and the request side backs up.
    always @(negedge clk)
    begin
        int run_len;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (long_hold)
        begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clk);
            long_hold = 0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            run_len = $urandom_range(1, 30);
            case ($urandom_range(0, 2))
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= 1'b1;
                default: rsp_stall <= ($urandom_range(0, 3) == 0);
            endcase
            repeat (run_len - 1) @(negedge clk);
        end
    end

    // Sends one item and records what it should produce. If a check value is supplied
    // the predictor result must also agree with it.
    task automatic send_item(in_item_t p, bit has_ref, out_item_t ref_rsp);
        out_item_t pred;
        req <= p;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = track_item(p);
        if (has_ref && pred !== ref_rsp)
        begin
            $error("directed row: expected %p, predicted %p", ref_rsp, pred);
            errors++;
        end
        expected_rsp.push_back(has_ref ? ref_rsp : pred);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk);
    endtask

    // Lets the block drain before a configuration write.
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge clk);
        repeat (3 * CONN_ENTRIES + 10) @(negedge clk);
    endtask

    task automatic write_timeout(logic [1:0] idx, logic [15:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_EST_TO: est_to = val;
            REG_TRN_TO: trn_to = val;
            default: uns_to = val;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic in_item_t pkt(logic d, logic [31:0] iip, logic [15:0] ip,
                                     logic [31:0] eip, logic [15:0] ep, logic s, logic a,
                                     logic [31:0] sq, logic [31:0] an);
        in_item_t p;
        p.kind = OP_PACKET;
        p.direction = d;
        p.int_ip = iip;
        p.int_port = ip;
        p.ext_ip = eip;
        p.ext_port = ep;
        p.syn_flag = s;
        p.ack_flag = a;
        p.seq_no = sq;
        p.ack_no = an;
        return p;
    endfunction

    function automatic in_item_t tick_item();
        in_item_t p;
        p = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, 4'($urandom)});
        p.kind = OP_TICK;
        return p;
    endfunction

    // Directed table: one row per item, with a typed-in result where it is obvious.
    typedef struct {
        in_item_t  p;
        bit        has_ref;
        out_item_t r;
    } row_t;

    row_t rows[$];

    task automatic add_row(in_item_t p, bit has_ref, out_item_t r);
        row_t rw;
        rw.p = p;
        rw.has_ref = has_ref;
        rw.r = r;
        rows.push_back(rw);
    endtask

    // Key pool for random traffic: a few connections so that hits and inserts are common.
    logic [31:0] pool_iip [8];
    logic [15:0] pool_ip  [8];
    logic [31:0] pool_eip [8];
    logic [15:0] pool_ep  [8];
    logic [31:0] pool_iseq [8];
    logic [31:0] pool_eseq [8];

    // Random packet: mostly well-formed handshake steps on pooled connections.
    function automatic in_item_t random_packet();
        int k;
        int step;
        in_item_t p;
        k = $urandom_range(0, 7);
        step = $urandom_range(0, 9);
        p = pkt(M_IN, pool_iip[k], pool_ip[k], pool_eip[k], pool_ep[k], 0, 0,
                $urandom, $urandom);
        case (step)
            0: begin p.direction = M_OUT; p.syn_flag = 1; pool_iseq[k] = p.seq_no; end
            1: begin p.direction = M_IN; p.syn_flag = 1; pool_eseq[k] = p.seq_no; end
            2: begin
                p.direction = M_IN; p.syn_flag = 1; p.ack_flag = 1;
                p.ack_no = pool_iseq[k] + 32'd1; pool_eseq[k] = p.seq_no;
            end
            3: begin
                p.direction = M_OUT; p.syn_flag = 1; p.ack_flag = 1;
                p.ack_no = pool_eseq[k] + 32'd1; pool_iseq[k] = p.seq_no;
            end
            4: begin p.direction = M_OUT; p.ack_flag = 1; end
            5: begin p.direction = M_IN; p.ack_flag = 1; end
            6: begin p.direction = 1'($urandom); p.ack_flag = 1'($urandom); end
            7: begin p.direction = 1'($urandom); p.syn_flag = 1; p.ack_flag = 1; end
            default: p = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     4'($urandom)});
        endcase
        if (step == 8 || step == 9)
            p.kind = OP_PACKET;
        return p;
    endfunction

    initial
    begin
        in_item_t p;
        int burst;
        int sent;
        logic [31:0] a;
        logic [31:0] b;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tracker_reset();
        for (int k = 0; k < 8; k++)
        begin
            pool_iip[k] = (k < 4) ? 32'hC0A8_0001 : $urandom;
            pool_ip[k] = (k == 0) ? 16'hFFFF : 16'($urandom);
            pool_eip[k] = (k == 1) ? 32'hFFFF_FFFF : $urandom;
            pool_ep[k] = (k == 2) ? 16'h0000 : 16'($urandom);
            pool_iseq[k] = 32'hFFFF_FFFF;
            pool_eseq[k] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under reset timeouts: rejects, insert, full handshake,
        // ack mismatch, wrap of the sequence sum, simultaneous open, dropped SYN, ticks.
        a = 32'hFFFF_FFFF;
        b = 32'h0000_0000;
        add_row(tick_item(), 1, mk_rsp(STS_TICK, 0, 0, 0));
        add_row(pkt(M_IN, a, 16'hFFFF, a, 16'hFFFF, 0, 1, a, a), 1,
                mk_rsp(STS_NOT_SYN, 0, 0, 0));
        // Outbound SYN, then the answering SYN-ACK, then the closing ACK.
        add_row(pkt(M_OUT, a, 16'hFFFF, b, 16'h0, 1, 0, a, b), 1, mk_rsp(STS_INSERTED, 0, 0, 0));
        add_row(pkt(M_IN, a, 16'hFFFF, b, 16'h0, 1, 1, 32'h1234, 32'h1), 1,
                mk_rsp(STS_ACK_BAD, 0, 0, 0));
        add_row(pkt(M_IN, a, 16'hFFFF, b, 16'h0, 1, 1, 32'h1234, 32'h0), 1,
                mk_rsp(STS_UPDATED, 0, 0, 0));
        add_row(pkt(M_OUT, a, 16'hFFFF, b, 16'h0, 0, 1, 32'h0, 32'h1235), 1,
                mk_rsp(STS_UPDATED, 1, 0, 0));
        // Inbound SYN first, outbound SYN within the unsolicited window is dropped.
        add_row(pkt(M_IN, b, 16'h0, a, 16'hFFFF, 1, 0, 32'h100, b), 1,
                mk_rsp(STS_INSERTED, 0, 0, 0));
        add_row(pkt(M_OUT, b, 16'h0, a, 16'hFFFF, 1, 0, 32'h500, b), 1,
                mk_rsp(STS_SYN_DROP, 0, 0, 0));
        // Simultaneous open on a third connection.
        add_row(pkt(M_OUT, 32'h1, 16'h1, 32'h2, 16'h2, 1, 0, 32'h10, b), 1,
                mk_rsp(STS_INSERTED, 0, 0, 0));
        add_row(pkt(M_IN, 32'h1, 16'h1, 32'h2, 16'h2, 1, 0, 32'h20, b), 0, '0);
        add_row(pkt(M_OUT, 32'h1, 16'h1, 32'h2, 16'h2, 1, 1, 32'h10, 32'h21), 0, '0);
        add_row(pkt(M_IN, 32'h1, 16'h1, 32'h2, 16'h2, 1, 1, 32'h20, 32'h11), 0, '0);
        // SYN-ACK on a miss counts as a plain SYN.
        add_row(pkt(M_IN, 32'h3, 16'h3, 32'h4, 16'h4, 1, 1, a, a), 1,
                mk_rsp(STS_INSERTED, 0, 0, 0));
        for (int t = 0; t < 7; t++)
            add_row(tick_item(), 0, '0);
        foreach (rows[r])
            send_item(rows[r].p, rows[r].has_ref, rows[r].r);

        // Fill the table to see the full status.
        for (int n = 0; n < CONN_ENTRIES + 1; n++)
            send_item(pkt(M_OUT, 32'hAA00_0000 + n, 16'(n), 32'h5, 16'h5, 1, 0, n, 0), 0, '0);
        drain();

        // Phases with different timeouts; zeros and maxima included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin
                    write_timeout(REG_EST_TO, 16'd0);
                    write_timeout(REG_TRN_TO, 16'd0);
                    write_timeout(REG_UNS_TO, 16'd0);
                end
                1: begin
                    write_timeout(REG_EST_TO, 16'hFFFF);
                    write_timeout(REG_TRN_TO, 16'hFFFF);
                    write_timeout(REG_UNS_TO, 16'hFFFF);
                end
                2: begin
                    write_timeout(REG_EST_TO, 16'd1);
                    write_timeout(REG_TRN_TO, 16'd1);
                    write_timeout(REG_UNS_TO, 16'd1);
                end
                default: begin
                    write_timeout(REG_EST_TO, 16'($urandom_range(2, 40)));
                    write_timeout(REG_TRN_TO, 16'($urandom_range(2, 20)));
                    write_timeout(REG_UNS_TO, 16'($urandom_range(0, 8)));
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 5)
            begin
                burst = $urandom_range(1, 40);
                if (ph == 3 && sent == 0)
                    long_hold = 1;
                for (int j = 0; j < burst && sent < RANDOM_ITEMS / 5; j++)
                begin
                    p = ($urandom_range(0, 5) == 0) ? tick_item() : random_packet();
                    send_item(p, 0, '0);
                    sent++;
                end
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- tcp_connection_tracker.f -----
rtl/tct_pkg.sv
rtl/tct_front.sv
rtl/tct_engine.sv
rtl/tcp_connection_tracker.sv
tb/tcp_connection_tracker_tb.sv
